/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// Simulation builds get concurrent assertions clocked on clk and disabled
// while arst_n is low. Synthesis builds get empty bodies.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks that the property holds at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
// Checks that the expression is never true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

/* rtl/wwpe_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wwpe_pkg: shared types and constants
// Payload structs, operation and register codes and sequencer states.
// ---------------------------------------------------------------------------
package wwpe_pkg;

	localparam int TAG_W     = 16;
	localparam int WEIGHT_W  = 16;
	localparam int CNT_OUT_W = 6;
	localparam int TOT_OUT_W = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int MAXMSG_W  = 6;
	localparam int MAXTOK_W  = 24;

	// Operation codes.
	localparam logic [1:0] OP_APPEND  = 2'd0;
	localparam logic [1:0] OP_CLEAR   = 2'd1;
	localparam logic [1:0] OP_TRIM    = 2'd2;
	localparam logic [1:0] OP_RESTORE = 2'd3;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TOKENS   = 2'd1;

	localparam logic [MAXMSG_W-1:0] MAXMSG_RESET = 6'd32;
	localparam logic [MAXTOK_W-1:0] MAXTOK_RESET = 24'hFFFFFF;

	typedef struct packed {
		logic [1:0]          opcode;
		logic [TAG_W-1:0]    entry_tag;
		logic [WEIGHT_W-1:0] weight;
		logic                is_system;
		logic                is_streaming;
	} req_t;

	typedef struct packed {
		logic                 kind;
		logic [TAG_W-1:0]     evicted_tag;
		logic [WEIGHT_W-1:0]  evicted_weight;
		logic [CNT_OUT_W-1:0] entry_count;
		logic [TOT_OUT_W-1:0] total_weight;
		logic                 dropped;
		logic                 last;
	} rsp_t;

	// One stored entry.
	typedef struct packed {
		logic                pin;
		logic [WEIGHT_W-1:0] weight;
		logic [TAG_W-1:0]    tag;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_EVICT,
		ST_STATUS
	} state_t;

endpackage

/* rtl/wwpe_store.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wwpe_store: entry memory
// DEPTH+1 entries, one write port and one read port with registered data.
// ---------------------------------------------------------------------------
module wwpe_store #(
	parameter int DEPTH = 32
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [$clog2(DEPTH+1)-1:0]         waddr,
	input  wwpe_pkg::entry_t                   wdata,
	input  logic                               re,
	input  logic [$clog2(DEPTH+1)-1:0]         raddr,
	output wwpe_pkg::entry_t                   rdata
);

	wwpe_pkg::entry_t mem [DEPTH+1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/weighted_window_with_pinned_entries_top.sv */
`timescale 1ns / 1ps
// Sequence: a clear or restore goes from its transfer straight to its status. An append or
// trim goes through a check first; each eviction adds a scan over the memory read port
// and a result, then another check. A trim halted by pinned entries ends its scan in the
// status. The block takes one item at a time; result stalls keep it busy longer.
// Reset: arst_n clears the count, total, limits (to 32 and 16777215) and the sequencer.
// The entry memory is not cleared; only entries below the count are ever read.
// ---------------------------------------------------------------------------
// weighted_window_with_pinned_entries_top
// Ordered window of tagged, weighted entries with pinned marks. Appends and restores go
// to the tail; an append or trim evicts the oldest unpinned entry while the count or
// total weight exceeds its limit, reporting each eviction, then a final status.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module weighted_window_with_pinned_entries_top #(
	parameter int DEPTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  wwpe_pkg::req_t                     req,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output wwpe_pkg::rsp_t                     rsp,
	input  logic                               cfg_we,
	input  logic [wwpe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wwpe_pkg::CFG_W-1:0]         cfg_data
);

	// The store holds one entry more than DEPTH so that an append can land
	// before the trim brings the count back down.
	localparam int SLOTS     = DEPTH + 1;
	localparam int AW        = $clog2(SLOTS);
	localparam int CW        = $clog2(SLOTS + 1);
	localparam int TW        = $clog2(SLOTS * 65535 + 1);
	localparam int CMW       = (CW > wwpe_pkg::MAXMSG_W) ? CW : wwpe_pkg::MAXMSG_W;
	localparam int TMW       = (TW > wwpe_pkg::MAXTOK_W) ? TW : wwpe_pkg::MAXTOK_W;
	localparam int OCW       = (CW > wwpe_pkg::CNT_OUT_W) ? CW : wwpe_pkg::CNT_OUT_W;
	localparam int OTW       = (TW > wwpe_pkg::TOT_OUT_W) ? TW : wwpe_pkg::TOT_OUT_W;
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

	wwpe_pkg::state_t state_q, state_d;

	// Architectural state and limits.
	logic [CW-1:0]                  cnt_q;
	logic [TW-1:0]                  total_q;
	logic [wwpe_pkg::MAXMSG_W-1:0]  max_msg_q;
	logic [wwpe_pkg::MAXTOK_W-1:0]  max_tok_q;

	// Per-item working registers.
	logic                           dropped_q;
	logic [CW-1:0]                  ra_q;     // next address to read in the scan
	logic                           dv_q;     // read data valid this cycle
	logic [AW-1:0]                  da_q;     // address of the data now returning
	logic                           found_q;  // oldest unpinned entry seen
	logic [wwpe_pkg::TAG_W-1:0]     ev_tag_q;
	logic [wwpe_pkg::WEIGHT_W-1:0]  ev_w_q;

	// Result register.
	logic                           rsp_valid_q;
	wwpe_pkg::rsp_t                 rsp_q;

	// Memory interface.
	logic                           mem_we;
	logic [AW-1:0]                  mem_waddr;
	wwpe_pkg::entry_t               mem_wdata;
	logic                           mem_re;
	wwpe_pkg::entry_t               mem_rdata;

	logic                           accept;
	logic                           is_append;
	logic                           room;
	logic                           need_trim;
	logic                           out_free;
	logic                           scan_done;
	wwpe_pkg::entry_t               new_entry;

	assign req_ready = (state_q == wwpe_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign is_append = (req.opcode == wwpe_pkg::OP_APPEND) ||
		(req.opcode == wwpe_pkg::OP_RESTORE);
	assign room      = (cnt_q < SLOTS_C);
	assign out_free  = !rsp_valid_q || rsp_ready;

	// Trim continues while either limit is exceeded and more than one entry remains.
	assign need_trim = ((CMW'(cnt_q) > CMW'(max_msg_q)) || (TMW'(total_q) > TMW'(max_tok_q)))
		&& (cnt_q > CW'(1));

	// The scan streams reads over entries 0 .. count-1. Data comes back in the
	// next cycle; once the oldest unpinned entry is seen, each later entry
	// is written back one place lower, closing the gap in the same pass.
	assign mem_re    = (state_q == wwpe_pkg::ST_SCAN) && (ra_q < cnt_q);
	assign scan_done = (state_q == wwpe_pkg::ST_SCAN) && !dv_q && !mem_re;

	always_comb begin
		new_entry.pin    = req.is_system || req.is_streaming;
		new_entry.weight = req.weight;
		new_entry.tag    = req.entry_tag;
	end

	always_comb begin
		if (state_q == wwpe_pkg::ST_SCAN) begin
			mem_we    = dv_q && found_q;
			mem_waddr = da_q - AW'(1);
			mem_wdata = mem_rdata;
		end else begin
			mem_we    = accept && is_append && room;
			mem_waddr = cnt_q[AW-1:0];
			mem_wdata = new_entry;
		end
	end

	wwpe_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (ra_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wwpe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wwpe_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req.opcode)
						wwpe_pkg::OP_APPEND,
						wwpe_pkg::OP_TRIM:    state_d = wwpe_pkg::ST_CHECK;
						wwpe_pkg::OP_CLEAR,
						wwpe_pkg::OP_RESTORE: state_d = wwpe_pkg::ST_STATUS;
						default:              state_d = wwpe_pkg::ST_STATUS;
					endcase
				end
			end
			wwpe_pkg::ST_CHECK: begin
				state_d = need_trim ? wwpe_pkg::ST_SCAN : wwpe_pkg::ST_STATUS;
			end
			wwpe_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = found_q ? wwpe_pkg::ST_EVICT : wwpe_pkg::ST_STATUS;
				end
			end
			wwpe_pkg::ST_EVICT: begin
				if (out_free) begin
					state_d = wwpe_pkg::ST_CHECK;
				end
			end
			wwpe_pkg::ST_STATUS: begin
				if (out_free) begin
					state_d = wwpe_pkg::ST_IDLE;
				end
			end
			default: state_d = wwpe_pkg::ST_IDLE;
		endcase
	end

	// Count, total, limits and scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			total_q   <= '0;
			max_msg_q <= wwpe_pkg::MAXMSG_RESET;
			max_tok_q <= wwpe_pkg::MAXTOK_RESET;
			dropped_q <= 1'b0;
			ra_q      <= '0;
			dv_q      <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			// The user must write the configuration only while the block is idle; the block itself does not enforce it.
			if (cfg_we) begin
				unique case (cfg_index)
					wwpe_pkg::REG_MAX_MESSAGES: max_msg_q <= cfg_data[wwpe_pkg::MAXMSG_W-1:0];
					wwpe_pkg::REG_MAX_TOKENS:   max_tok_q <= cfg_data[wwpe_pkg::MAXTOK_W-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				dropped_q <= 1'b0;
				if (req.opcode == wwpe_pkg::OP_CLEAR) begin
					cnt_q   <= '0;
					total_q <= '0;
				end else if (is_append) begin
					if (room) begin
						cnt_q   <= cnt_q + CW'(1);
						total_q <= total_q + TW'(req.weight);
					end else begin
						dropped_q <= 1'b1;
					end
				end
			end

			if ((state_q == wwpe_pkg::ST_CHECK) && need_trim) begin
				ra_q    <= '0;
				dv_q    <= 1'b0;
				found_q <= 1'b0;
			end

			if (state_q == wwpe_pkg::ST_SCAN) begin
				dv_q <= mem_re;
				if (mem_re) begin
					ra_q <= ra_q + CW'(1);
				end
				if (dv_q && !found_q && !mem_rdata.pin) begin
					found_q <= 1'b1;
				end
				if (scan_done && found_q) begin
					cnt_q   <= cnt_q - CW'(1);
					total_q <= total_q - TW'(ev_w_q);
				end
			end
		end
	end

	// Payload registers of the scan.
	always_ff @(posedge clk) begin
		if (mem_re) begin
			da_q <= ra_q[AW-1:0];
		end
		if ((state_q == wwpe_pkg::ST_SCAN) && dv_q && !found_q && !mem_rdata.pin) begin
			ev_tag_q <= mem_rdata.tag;
			ev_w_q   <= mem_rdata.weight;
		end
	end

	// Result register: a result waits here for its transfer while the
	// sequencer moves on to the next step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (((state_q == wwpe_pkg::ST_EVICT) || (state_q == wwpe_pkg::ST_STATUS))
			&& out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			rsp_q.entry_count  <= wwpe_pkg::CNT_OUT_W'(OCW'(cnt_q));
			rsp_q.total_weight <= wwpe_pkg::TOT_OUT_W'(OTW'(total_q));
			if (state_q == wwpe_pkg::ST_EVICT) begin
				rsp_q.kind           <= 1'b0;
				rsp_q.evicted_tag    <= ev_tag_q;
				rsp_q.evicted_weight <= ev_w_q;
				rsp_q.dropped        <= 1'b0;
				rsp_q.last           <= 1'b0;
			end else if (state_q == wwpe_pkg::ST_STATUS) begin
				rsp_q.kind           <= 1'b1;
				rsp_q.evicted_tag    <= '0;
				rsp_q.evicted_weight <= '0;
				rsp_q.dropped        <= dropped_q;
				rsp_q.last           <= 1'b1;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The count never exceeds the number of slots.
	`ASSERT_ALWAYS(a_cnt_bound, cnt_q <= SLOTS_C, "entry count exceeds store size")
	// A shift write targets the slot below the returning data and never wraps below slot zero.
	`ASSERT_NEVER(a_shift_addr, (state_q == wwpe_pkg::ST_SCAN) && dv_q && found_q
		&& (da_q == '0), "shift write below slot zero")
	// An eviction is only reported while at least one entry remains.
	`ASSERT_ALWAYS(a_evict_cnt, (state_q == wwpe_pkg::ST_EVICT) |-> (cnt_q != '0),
		"eviction with an empty store")
	// The block takes no new item while a scan is in progress.
	`ASSERT_ALWAYS(a_busy, (state_q == wwpe_pkg::ST_SCAN) |-> !req_ready,
		"item transfer during a scan")

endmodule

/* sim/weighted_window_with_pinned_entries_top_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// weighted_window_with_pinned_entries_top_test
// Self-checking bench for the weighted window. A behavioral copy of the window
// (entry list, count, total and both limits) predicts every eviction notice and
// status. Directed tests cover the opcodes, field extremes, a full store,
// pinned entries and zero limits. Random traffic with changing limits follows.
// ---------------------------------------------------------------------------
module weighted_window_with_pinned_entries_top_test;

	localparam int DEPTH       = 32;
	localparam int SLOTS       = DEPTH + 1;
	localparam int HALF_PERIOD = 6;
	localparam int CYCLE_LIMIT = 3000000;
	// Cycles allowed after the last status before the block counts as idle.
	localparam int IDLE_GUARD  = 4;
	localparam int MAX_GAP     = 40;
	localparam int MAX_REPORTS = 10;

	// Result kinds as carried in rsp.kind.
	localparam logic KIND_EVICT  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Register indexes with nothing behind them; writes there must be ignored.
	localparam logic [wwpe_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
	localparam logic [wwpe_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           req_valid;
	logic                           req_ready;
	wwpe_pkg::req_t                 req;
	logic                           rsp_valid;
	logic                           rsp_ready = 1'b0;
	wwpe_pkg::rsp_t                 rsp;
	logic                           cfg_we;
	logic [wwpe_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [wwpe_pkg::CFG_W-1:0]     cfg_data;

	// Behavioral copy of the window: oldest entry at index 0.
	wwpe_pkg::entry_t               window_model[$];
	int unsigned                    held_weight = 0;
	logic [wwpe_pkg::MAXMSG_W-1:0]  lim_count   = wwpe_pkg::MAXMSG_RESET;
	logic [wwpe_pkg::MAXTOK_W-1:0]  lim_weight  = wwpe_pkg::MAXTOK_RESET;

	// Results predicted but not yet seen on the response channel, oldest first.
	wwpe_pkg::rsp_t                 awaited_rsp[$];

	// Idle rates, in percent per cycle, for the request and response sides.
	int                   send_idle_pct  = 0;
	int                   recv_stall_pct = 0;

	int                   fail_count      = 0;
	int                   results_checked = 0;
	int                   requests_sent   = 0;
	int                   evictions_due   = 0;
	int                   refusals_due    = 0;
	int                   longest_run     = 0;
	int                   limit_writes    = 0;

	weighted_window_with_pinned_entries_top #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// The response side stalls at random with the current stall rate. A rate
	// of zero keeps ready high on every cycle.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: a run that is still going at the limit has hung somewhere.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	function automatic string rsp_text(input wwpe_pkg::rsp_t r);
		return $sformatf("kind=%0d tag=%04h weight=%04h count=%0d total=%06h dropped=%0d last=%0d",
			r.kind, r.evicted_tag, r.evicted_weight, r.entry_count, r.total_weight,
			r.dropped, r.last);
	endfunction

	function automatic void report_fail(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) begin
			$display("ERROR: %s", msg);
		end
	endfunction

	// Applies one accepted request to the window copy and queues the eviction
	// notices it causes, followed by its status.
	function automatic void advance_window(input wwpe_pkg::req_t item);
		wwpe_pkg::rsp_t   note;
		wwpe_pkg::entry_t slot;
		logic   refused;
		int     found;
		int     run;
		refused = 1'b0;
		run = 0;
		if (item.opcode == wwpe_pkg::OP_APPEND || item.opcode == wwpe_pkg::OP_RESTORE) begin
			if (window_model.size() >= SLOTS) begin
				// Store already holds DEPTH+1 entries: the new one is refused.
				refused = 1'b1;
			end else begin
				slot.tag = item.entry_tag;
				slot.weight = item.weight;
				slot.pin = item.is_system | item.is_streaming;
				window_model.push_back(slot);
				held_weight += item.weight;
			end
		end else if (item.opcode == wwpe_pkg::OP_CLEAR) begin
			window_model.delete();
			held_weight = 0;
		end
		if (item.opcode == wwpe_pkg::OP_APPEND || item.opcode == wwpe_pkg::OP_TRIM) begin
			// Evict the oldest unpinned entry while a limit is exceeded, but never
			// the last entry, and stop once only pinned entries are left.
			while ((window_model.size() > lim_count || held_weight > lim_weight)
					&& window_model.size() > 1) begin
				found = -1;
				for (int i = 0; i < window_model.size(); i++) begin
					if (!window_model[i].pin) begin
						found = i;
						break;
					end
				end
				if (found < 0) begin
					break;
				end
				slot = window_model[found];
				window_model.delete(found);
				held_weight -= slot.weight;
				note = '0;
				note.kind = KIND_EVICT;
				note.evicted_tag = slot.tag;
				note.evicted_weight = slot.weight;
				note.entry_count = wwpe_pkg::CNT_OUT_W'(window_model.size());
				note.total_weight = wwpe_pkg::TOT_OUT_W'(held_weight);
				awaited_rsp.push_back(note);
				run++;
			end
		end
		evictions_due += run;
		if (run > longest_run) begin
			longest_run = run;
		end
		if (refused) begin
			refusals_due++;
		end
		note = '0;
		note.kind = KIND_STATUS;
		note.entry_count = wwpe_pkg::CNT_OUT_W'(window_model.size());
		note.total_weight = wwpe_pkg::TOT_OUT_W'(held_weight);
		note.dropped = refused;
		note.last = 1'b1;
		awaited_rsp.push_back(note);
	endfunction

	// Every result transfer is compared with the oldest prediction.
	always @(posedge clk) begin
		wwpe_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				report_fail($sformatf("result with nothing predicted: %s", rsp_text(rsp)));
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.kind !== want.kind || rsp.evicted_tag !== want.evicted_tag
						|| rsp.evicted_weight !== want.evicted_weight
						|| rsp.entry_count !== want.entry_count
						|| rsp.total_weight !== want.total_weight
						|| rsp.dropped !== want.dropped || rsp.last !== want.last) begin
					report_fail($sformatf("result %0d: expected %s, got %s",
						results_checked, rsp_text(want), rsp_text(rsp)));
				end
				results_checked++;
			end
		end
	end

	function automatic wwpe_pkg::req_t make_item(input logic [1:0] op,
			input logic [wwpe_pkg::TAG_W-1:0] tag,
			input logic [wwpe_pkg::WEIGHT_W-1:0] weight, input logic sys, input logic strm);
		wwpe_pkg::req_t r;
		r.opcode = op;
		r.entry_tag = tag;
		r.weight = weight;
		r.is_system = sys;
		r.is_streaming = strm;
		return r;
	endfunction

	function automatic logic [wwpe_pkg::WEIGHT_W-1:0] nonzero_weight();
		return wwpe_pkg::WEIGHT_W'($urandom_range(1, 65535));
	endfunction

	// Random content; weights lean toward zero, full scale and small values so
	// that token limits are hit from both sides.
	function automatic wwpe_pkg::req_t random_entry(input logic [1:0] op);
		wwpe_pkg::req_t r;
		r.opcode = op;
		r.entry_tag = wwpe_pkg::TAG_W'($urandom_range(0, 65535));
		case ($urandom_range(9))
			0: begin
				r.weight = '0;
			end
			1: begin
				r.weight = '1;
			end
			2, 3, 4: begin
				r.weight = wwpe_pkg::WEIGHT_W'($urandom_range(0, 255));
			end
			default: begin
				r.weight = wwpe_pkg::WEIGHT_W'($urandom_range(0, 65535));
			end
		endcase
		r.is_system = ($urandom_range(99) < 15);
		r.is_streaming = ($urandom_range(99) < 15);
		return r;
	endfunction

	function automatic wwpe_pkg::req_t unpinned_entry(input logic [1:0] op);
		wwpe_pkg::req_t r;
		r = random_entry(op);
		r.is_system = 1'b0;
		r.is_streaming = 1'b0;
		return r;
	endfunction

	// Offers one request after a random gap and returns at the edge where it
	// transfers. Valid stays high into the next call when there is no gap.
	task automatic send_request(input wwpe_pkg::req_t item);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do begin
			@(posedge clk);
		end while (!req_ready);
		advance_window(item);
		requests_sent++;
	endtask

	// Waits until every predicted result has arrived and the sequencer has
	// had time to return to idle.
	task automatic wait_window_idle();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) begin
			@(posedge clk);
		end
		repeat (IDLE_GUARD) @(posedge clk);
	endtask

	// Limits only change while the window is idle.
	task automatic write_limit(input logic [wwpe_pkg::CFG_IDX_W-1:0] idx,
			input logic [wwpe_pkg::CFG_W-1:0] value);
		wait_window_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			wwpe_pkg::REG_MAX_MESSAGES: begin
				lim_count = value[wwpe_pkg::MAXMSG_W-1:0];
			end
			wwpe_pkg::REG_MAX_TOKENS: begin
				lim_weight = value[wwpe_pkg::MAXTOK_W-1:0];
			end
			default: begin
			end
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
		limit_writes++;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Every opcode at least once with extreme fields, then count and token limits that
	// each force evictions past a pinned entry.
	task automatic test_basic_ops();
		write_limit(wwpe_pkg::REG_MAX_MESSAGES, 24'd32);
		write_limit(wwpe_pkg::REG_MAX_TOKENS, 24'hFFFFFF);
		send_request(make_item(wwpe_pkg::OP_RESTORE, 16'h0000, 16'h0000, 1'b0, 1'b0));
		send_request(make_item(wwpe_pkg::OP_APPEND, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
		send_request(make_item(wwpe_pkg::OP_APPEND, 16'h1234, 16'h0001, 1'b0, 1'b1));
		send_request(make_item(wwpe_pkg::OP_APPEND, 16'h8000, 16'h8000, 1'b1, 1'b1));
		// Trim and clear must ignore whatever sits in the entry fields.
		send_request(make_item(wwpe_pkg::OP_TRIM, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
		send_request(make_item(wwpe_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));

		write_limit(wwpe_pkg::REG_MAX_MESSAGES, 24'd2);
		send_request(make_item(wwpe_pkg::OP_APPEND, 16'hA001, 16'h0100, 1'b0, 1'b0));
		send_request(make_item(wwpe_pkg::OP_APPEND, 16'hA002, 16'h0010, 1'b1, 1'b0));
		send_request(make_item(wwpe_pkg::OP_APPEND, 16'hA003, 16'h0200, 1'b0, 1'b0));
		send_request(make_item(wwpe_pkg::OP_APPEND, 16'hA004, 16'h0300, 1'b0, 1'b0));
		// A restore goes past the count limit without trimming; the trim after it
		// catches up.
		send_request(make_item(wwpe_pkg::OP_RESTORE, 16'hA005, 16'h0400, 1'b0, 1'b0));
		send_request(make_item(wwpe_pkg::OP_TRIM, 16'h5555, 16'hAAAA, 1'b0, 1'b1));

		// Token limit alone: the append evicts the older unpinned entry and then
		// itself, leaving only the pinned one.
		write_limit(wwpe_pkg::REG_MAX_MESSAGES, 24'd32);
		write_limit(wwpe_pkg::REG_MAX_TOKENS, 24'h000100);
		send_request(make_item(wwpe_pkg::OP_APPEND, 16'hA006, 16'h0200, 1'b0, 1'b0));
		send_request(make_item(wwpe_pkg::OP_CLEAR, 16'h0000, 16'h0000, 1'b0, 1'b0));
		write_limit(wwpe_pkg::REG_MAX_TOKENS, 24'hFFFFFF);
	endtask

	// Fills all DEPTH+1 slots, then appends that must be refused, one of them
	// still followed by a trim, then a trim with a zero count limit.
	task automatic test_full_store();
		write_limit(wwpe_pkg::REG_MAX_MESSAGES, 24'd32);
		write_limit(wwpe_pkg::REG_MAX_TOKENS, 24'hFFFFFF);
		send_request(random_entry(wwpe_pkg::OP_CLEAR));
		for (int i = 0; i < SLOTS; i++) begin
			send_request(random_entry(wwpe_pkg::OP_RESTORE));
		end
		send_request(random_entry(wwpe_pkg::OP_RESTORE));
		send_request(random_entry(wwpe_pkg::OP_APPEND));
		write_limit(wwpe_pkg::REG_MAX_MESSAGES, 24'd0);
		send_request(random_entry(wwpe_pkg::OP_TRIM));
		send_request(random_entry(wwpe_pkg::OP_CLEAR));
		write_limit(wwpe_pkg::REG_MAX_MESSAGES, 24'd32);
	endtask

	// With a zero token limit and only pinned entries, nothing can be evicted
	// and the limit stays exceeded. An unpinned newcomer is evicted at once.
	task automatic test_all_pinned();
		write_limit(wwpe_pkg::REG_MAX_TOKENS, 24'd0);
		send_request(random_entry(wwpe_pkg::OP_CLEAR));
		send_request(make_item(wwpe_pkg::OP_APPEND, 16'hB001, nonzero_weight(), 1'b1, 1'b0));
		send_request(make_item(wwpe_pkg::OP_APPEND, 16'hB002, nonzero_weight(), 1'b0, 1'b1));
		send_request(make_item(wwpe_pkg::OP_APPEND, 16'hB003, nonzero_weight(), 1'b1, 1'b1));
		send_request(make_item(wwpe_pkg::OP_APPEND, 16'hB004, 16'hFFFF, 1'b1, 1'b0));
		send_request(random_entry(wwpe_pkg::OP_TRIM));
		send_request(make_item(wwpe_pkg::OP_APPEND, 16'hB005, 16'h0000, 1'b0, 1'b0));
		send_request(random_entry(wwpe_pkg::OP_CLEAR));
		write_limit(wwpe_pkg::REG_MAX_TOKENS, 24'hFFFFFF);
	endtask

	// Both limits at zero: every trim keeps exactly one entry. Writes to the
	// unmapped indexes in between must leave the limits alone.
	task automatic test_zero_limits();
		write_limit(wwpe_pkg::REG_MAX_MESSAGES, 24'd0);
		write_limit(wwpe_pkg::REG_MAX_TOKENS, 24'd0);
		send_request(random_entry(wwpe_pkg::OP_CLEAR));
		repeat (4) send_request(unpinned_entry(wwpe_pkg::OP_APPEND));
		repeat (3) send_request(unpinned_entry(wwpe_pkg::OP_RESTORE));
		send_request(random_entry(wwpe_pkg::OP_TRIM));
		write_limit(REG_UNMAPPED_LO, 24'hFFFFFF);
		write_limit(REG_UNMAPPED_HI, 24'h000021);
		repeat (2) send_request(unpinned_entry(wwpe_pkg::OP_RESTORE));
		send_request(random_entry(wwpe_pkg::OP_TRIM));
		// Only the low six bits reach the count limit, giving 63 here.
		write_limit(wwpe_pkg::REG_MAX_MESSAGES, 24'hFFFFFF);
		write_limit(wwpe_pkg::REG_MAX_TOKENS, 24'hFFFFFF);
	endtask

	// New limits for a stretch of random traffic, extremes included. The count
	// limit sometimes gets random upper bits and a value above the store size.
	task automatic pick_limits();
		logic [wwpe_pkg::CFG_W-1:0] count_lim;
		logic [wwpe_pkg::CFG_W-1:0] weight_lim;
		case ($urandom_range(5))
			0: begin
				count_lim = 24'd0;
			end
			1: begin
				count_lim = 24'd1;
			end
			2: begin
				count_lim = 24'd32;
			end
			3: begin
				count_lim = wwpe_pkg::CFG_W'($urandom());
			end
			default: begin
				count_lim = wwpe_pkg::CFG_W'($urandom_range(2, 24));
			end
		endcase
		case ($urandom_range(5))
			0: begin
				weight_lim = 24'd0;
			end
			1: begin
				weight_lim = 24'hFFFFFF;
			end
			2: begin
				weight_lim = wwpe_pkg::CFG_W'($urandom_range(1, 1000));
			end
			default: begin
				weight_lim = wwpe_pkg::CFG_W'($urandom_range(40000, 700000));
			end
		endcase
		if ($urandom_range(3) == 0) begin
			write_limit($urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
				wwpe_pkg::CFG_W'($urandom()));
		end
		write_limit(wwpe_pkg::REG_MAX_MESSAGES, count_lim);
		write_limit(wwpe_pkg::REG_MAX_TOKENS, weight_lim);
	endtask

	// Mostly well-formed traffic: runs of appends, restore bursts that build
	// the store up (often to full) followed by a trim, plus some stray trims,
	// clears and fully random requests.
	task automatic test_random_traffic(input int segments);
		int budget;
		int n;
		int pick;
		for (int seg = 0; seg < segments; seg++) begin
			pick_limits();
			budget = 25;
			while (budget > 0) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					n = $urandom_range(1, 10);
					repeat (n) send_request(random_entry(wwpe_pkg::OP_APPEND));
				end else if (pick < 65) begin
					n = $urandom_range(1, 12);
					repeat (n) send_request(random_entry(wwpe_pkg::OP_RESTORE));
					send_request(random_entry(wwpe_pkg::OP_TRIM));
					n++;
				end else if (pick < 75) begin
					n = 1;
					send_request(random_entry(wwpe_pkg::OP_TRIM));
				end else if (pick < 80) begin
					n = 1;
					send_request(random_entry(wwpe_pkg::OP_CLEAR));
				end else begin
					n = 1;
					send_request(random_entry(2'($urandom_range(0, 3))));
				end
				budget -= n;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender mostly busy, receiver mostly stalled: results back up.
		set_idling(9, 73);
		test_basic_ops();
		test_full_store();
		test_all_pinned();
		test_zero_limits();
		test_random_traffic(3);

		// Sender mostly idle, receiver mostly ready.
		set_idling(73, 9);
		test_random_traffic(6);

		// Back-to-back transfers on both sides.
		set_idling(0, 0);
		test_random_traffic(6);

		wait_window_idle();
		// Any stray result in this window shows up as unpredicted.
		repeat (2 * (SLOTS + 3)) @(posedge clk);

		$display("Sent %0d requests under %0d limit writes; checked %0d results.",
			requests_sent, limit_writes, results_checked);
		$display("Predicted %0d evictions (at most %0d per request), %0d refused appends.",
			evictions_due, longest_run, refusals_due);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatching or unpredicted results.", fail_count);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
